>>> hdl/tld_pkg.sv
// Shared types and constants for the tick-driven LED display driver.
// Used by the front, queue, back and top-level modules; depends on nothing.
package tld_pkg;

    // Display models selected by the model register.
    typedef enum logic [1:0] {
        MODEL_NONE     = 2'd0,
        MODEL_LCD      = 2'd1,
        MODEL_PARALLEL = 2'd2,
        MODEL_SERIAL   = 2'd3
    } t_model;

    // Configuration register indexes.
    localparam int unsigned    CFG_INDEX_W   = 3;
    localparam int unsigned    CFG_DATA_W    = 24;
    localparam logic [2:0]     REG_MODEL     = 3'd0;
    localparam logic [2:0]     REG_HEARTBEAT = 3'd1;
    localparam logic [2:0]     REG_DISK      = 3'd2;
    localparam logic [2:0]     REG_RECEIVE   = 3'd3;
    localparam logic [2:0]     REG_TRANSMIT  = 3'd4;

    // Target registers of a write.
    localparam logic PORT_CMD  = 1'b0;
    localparam logic PORT_DATA = 1'b1;

    localparam int unsigned TICKS_DEFAULT = 100;
    localparam int unsigned QUEUE_DEPTH   = 4;
    localparam int unsigned SERIAL_WRITES = 16;

    // One display job handed from the front to the back.
    typedef struct packed {
        logic       serial;  // expand into the serial data/strobe sequence
        logic       port;
        logic [7:0] data;
    } t_job;

endpackage

>>> hdl/tld_front.sv
// Front part: configuration registers, tick counter, LED pattern and job creation.
// Depends on tld_pkg.
module tld_front
    import tld_pkg::*;
#(
    parameter int unsigned TICKS_PER_SECOND = TICKS_DEFAULT
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_in_valid,
    input  logic                   i_tick,
    input  logic                   i_full,
    output logic                   o_in_stall,
    output logic                   o_push,
    output t_job                   o_job
);

    localparam int unsigned CW = $clog2(TICKS_PER_SECOND);
    localparam logic [CW-1:0] LAST  = CW'(TICKS_PER_SECOND - 1);
    localparam logic [CW-1:0] HALF  = CW'(TICKS_PER_SECOND / 2);
    localparam logic [CW-1:0] SIXT  = CW'(TICKS_PER_SECOND / 16);
    localparam logic [CW-1:0] HSIXT = CW'(TICKS_PER_SECOND / 2 + TICKS_PER_SECOND / 16);
    localparam logic          ODD   = 1'(TICKS_PER_SECOND % 2);

    t_model          r_model;
    logic [23:0]     r_codes [4];
    logic [CW-1:0]   r_count, n_count;
    logic [1:0]      r_pos, n_pos;
    logic            n_hb;
    logic [2:0]      r_roll, n_roll;
    logic [3:0]      r_shown;
    logic            r_shown_valid;
    logic [1:0]      r_slot, n_slot;
    logic            r_data_next, n_data_next;
    logic            w_go;
    logic            w_changed;
    logic [3:0]      w_pat;
    logic [23:0]     w_codes;

    assign o_in_stall = i_full;
    assign w_go = i_in_valid && !i_full && i_tick && (r_model != MODEL_NONE);
    assign w_codes = r_codes[r_slot];

    always_comb begin
        n_count = (r_count == LAST) ? '0 : r_count + 1'b1;
        // Heartbeat is on for a sixteenth of the period at the start of each half period;
        // with an odd rate the last count starts a short third half period.
        n_hb = (n_count < SIXT) || (n_count >= HALF && n_count < HSIXT)
             || (ODD && n_count == LAST);
        n_pos  = r_pos;
        n_roll = r_roll;
        if (n_count == '0) begin
            n_pos  = (r_pos >= 2'd2) ? 2'd0 : r_pos + 2'd1;
            n_roll = 3'b001 << n_pos;
        end
        w_pat     = {n_hb, n_roll};
        w_changed = !r_shown_valid || (r_shown != w_pat);

        n_slot      = r_slot;
        n_data_next = r_data_next;
        o_job       = '0;
        case (r_model)
            MODEL_LCD: begin
                if (r_data_next) begin
                    o_job.port  = PORT_DATA;
                    o_job.data  = w_pat[2'd3 - r_slot] ? w_codes[15:8] : w_codes[7:0];
                    n_data_next = 1'b0;
                    n_slot      = r_slot + 2'd1;
                end else begin
                    o_job.port  = PORT_CMD;
                    o_job.data  = w_codes[23:16];
                    n_data_next = 1'b1;
                end
            end
            MODEL_PARALLEL: begin
                o_job.port = PORT_CMD;
                o_job.data = ~{4'b0000, w_pat};
            end
            MODEL_SERIAL: begin
                o_job.serial = 1'b1;
                o_job.port   = PORT_CMD;
                o_job.data   = ~{4'b0000, w_pat};
            end
            default: begin
                o_job = '0;
            end
        endcase
        o_push = w_go && w_changed;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_model       <= MODEL_NONE;
            r_count       <= '0;
            r_pos         <= '0;
            r_roll        <= '0;
            r_shown_valid <= 1'b0;
            r_slot        <= '0;
            r_data_next   <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                r_codes[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_MODEL:     r_model    <= t_model'(i_cfg_data[1:0]);
                    REG_HEARTBEAT: r_codes[0] <= i_cfg_data;
                    REG_DISK:      r_codes[1] <= i_cfg_data;
                    REG_RECEIVE:   r_codes[2] <= i_cfg_data;
                    REG_TRANSMIT:  r_codes[3] <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_go) begin
                r_count <= n_count;
                r_pos   <= n_pos;
                r_roll  <= n_roll;
                if (w_changed) begin
                    r_shown_valid <= 1'b1;
                    r_slot        <= n_slot;
                    r_data_next   <= n_data_next;
                end
            end
        end
    end

    // The shown pattern is only read once it has been written.
    always_ff @(posedge i_clk) begin
        if (w_go && w_changed) begin
            r_shown <= w_pat;
        end
    end

endmodule

>>> hdl/tld_queue.sv
// Short job queue between the front and the back.
// Depends on tld_pkg.
module tld_queue
    import tld_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_job o_head
);

    localparam int unsigned AW = $clog2(QUEUE_DEPTH);

    t_job          r_mem [QUEUE_DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [AW:0]   r_fill;

    assign o_full  = (r_fill == (AW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_fill == '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_fill <= r_fill + 1'b1;
                2'b01:   r_fill <= r_fill - 1'b1;
                default: r_fill <= r_fill;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

>>> hdl/tld_back.sv
// Back part: expands queued jobs into register writes and holds the output register.
// Depends on tld_pkg.
module tld_back
    import tld_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_empty,
    input  t_job       i_head,
    output logic       o_pop,
    input  logic       i_out_stall,
    output logic       o_out_valid,
    output logic       o_target_port,
    output logic [7:0] o_write_byte,
    output logic       o_last_write
);

    localparam int unsigned SW = $clog2(SERIAL_WRITES);
    localparam logic [SW-1:0] STEP_LAST = SW'(SERIAL_WRITES - 1);

    logic [SW-1:0] r_step;
    logic          r_valid;
    logic          r_port;
    logic [7:0]    r_byte;
    logic          r_last;
    logic          w_load;
    logic          w_take;
    logic          n_port;
    logic [7:0]    n_byte;
    logic          n_last;
    logic          w_bit;

    assign w_load = !r_valid || !i_out_stall;
    assign w_take = w_load && !i_empty;

    always_comb begin
        // Serial: two writes per bit, MSB first, the second with the strobe set.
        w_bit  = i_head.data[3'd7 - r_step[SW-1:1]];
        n_port = i_head.port;
        if (i_head.serial) begin
            n_byte = {6'b000000, r_step[0], w_bit};
            n_last = (r_step == STEP_LAST);
        end else begin
            n_byte = i_head.data;
            n_last = 1'b1;
        end
        o_pop = w_take && n_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_step  <= '0;
        end else begin
            if (w_load) begin
                r_valid <= !i_empty;
            end
            if (w_take && i_head.serial) begin
                r_step <= n_last ? '0 : r_step + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_port <= n_port;
            r_byte <= n_byte;
            r_last <= n_last;
        end
    end

    assign o_out_valid   = r_valid;
    assign o_target_port = r_port;
    assign o_write_byte  = r_byte;
    assign o_last_write  = r_last;

endmodule

>>> hdl/tick_led_display_driver.sv
// Top level of the tick-driven LED display driver.
// Depends on tld_pkg, tld_front, tld_queue and tld_back.
//
// Usage: each request on the input channel (i_in_valid / o_in_stall) carries one
// timer tick in i_tick. A tick of 1 advances the tick counter, heartbeat and roll
// pattern; when the pattern differs from the one last shown (or nothing was shown
// yet), the display writes for it leave on the output channel (o_out_valid /
// i_out_stall) as target_port, write_byte and last_write, the last write of a tick
// flagged. A tick of 0, or any tick with display model none, produces nothing.
// The configuration port (i_cfg_we, i_cfg_index, i_cfg_data) sets the display
// model and the four LCD slot codes; the user must write it only while the block
// is idle, which the block itself does not enforce. Each tick's job passes a
// four-entry job queue, which separates front and back, and then the output
// register. The back emits one write per cycle unless the receiver stalls, so LCD
// and parallel ticks sustain one per cycle and serial ticks take sixteen writes each.
// When the receiver stalls, the output register holds its write, the queue fills
// and o_in_stall rises once the queue is full. Synchronous reset clears the
// counters, the pattern, the shown flag, the LCD slot state, the queue and the
// output valid; the model register resets to none and the slot codes to zero.
module tick_led_display_driver
    import tld_pkg::*;
#(
    parameter int unsigned TICKS_PER_SECOND = TICKS_DEFAULT
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic                   i_tick,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic                   o_target_port,
    output logic [7:0]             o_write_byte,
    output logic                   o_last_write
);

    logic w_push;
    logic w_pop;
    logic w_full;
    logic w_empty;
    t_job w_job;
    t_job w_head;

    // The front classifies each tick and turns a pattern change into one job.
    tld_front #(
        .TICKS_PER_SECOND(TICKS_PER_SECOND)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_tick      (i_tick),
        .i_full      (w_full),
        .o_in_stall  (o_in_stall),
        .o_push      (w_push),
        .o_job       (w_job)
    );

    // The queue lets the front keep accepting ticks while the back is busy.
    tld_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    // The back expands each job into one or sixteen writes.
    tld_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (w_empty),
        .i_head        (w_head),
        .o_pop         (w_pop),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_target_port (o_target_port),
        .o_write_byte  (o_write_byte),
        .o_last_write  (o_last_write)
    );

    // A job is never created while the queue has no room for it.
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("job pushed into a full queue");

    // Only serial writes are not the last of their tick, and they carry two bits.
    a_serial_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last_write) |-> (o_target_port == PORT_CMD
            && o_write_byte[7:2] == 6'b000000))
        else $error("non-final write is not a serial write");

    // An LCD data write is always the single write of its tick.
    a_lcd_data_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_target_port == PORT_DATA) |-> o_last_write)
        else $error("LCD data write not flagged as last");

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the tick-driven LED display driver.
// It depends on tld_pkg and the tick_led_display_driver top level, nothing else.
// A local predictor of the display writes checks every write the block makes.
module testbench;
    import tld_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // The block runs with its default tick rate, so the predictor uses the same one.
    localparam int TICKS         = TICKS_DEFAULT;
    localparam int CNT_W         = $clog2(TICKS);
    localparam int HOLD_LEN      = 1000;   // long receiver hold-off for the pressure test
    localparam int DRAIN_LIMIT   = 4000;   // cycles allowed for outstanding writes to arrive
    localparam int SETTLE_CYCLES = 8;      // covers the path through the queue and output register of the block
    localparam int CYCLE_LIMIT   = 200000;

    // One display write as the block reports it.
    typedef struct packed {
        logic       port;
        logic [7:0] data;
        logic       last;
    } t_write_rec;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data  = '0;
    logic                   i_in_valid  = 1'b0;
    logic                   o_in_stall;
    logic                   i_tick      = 1'b0;
    logic                   o_out_valid;
    logic                   i_out_stall = 1'b0;
    logic                   o_target_port;
    logic [7:0]             o_write_byte;
    logic                   o_last_write;

    tick_led_display_driver u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_tick        (i_tick),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_target_port (o_target_port),
        .o_write_byte  (o_write_byte),
        .o_last_write  (o_last_write)
    );

    always #2 i_clk = ~i_clk;

    // Shadow copy of the configuration registers.
    t_model      sh_model = MODEL_NONE;
    logic [23:0] sh_codes [4] = '{default: '0};

    // Shadow copy of the block's internal state.
    logic [CNT_W-1:0] tick_ctr  = '0;
    logic [1:0]       roll_idx  = '0;
    logic [7:0]       pattern   = '0;
    logic [7:0]       shown     = '0;
    logic             shown_ok  = 1'b0;
    logic [1:0]       lcd_slot  = '0;
    logic             data_next = 1'b0;

    // Writes that are still owed by the block, oldest first.
    t_write_rec pending_writes[$];
    int         predicted_writes = 0;
    int         mismatches       = 0;

    // Receiver pattern controls. The test bumps hold_requests to ask for a hold-off.
    int stall_pct     = 0;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    int run_left      = 0;

    // Updates the shadow registers for one configuration write.
    task automatic set_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [23:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        case (idx)
            REG_MODEL:     sh_model = t_model'(value[1:0]);
            REG_HEARTBEAT: sh_codes[0] = value;
            REG_DISK:      sh_codes[1] = value;
            REG_RECEIVE:   sh_codes[2] = value;
            REG_TRANSMIT:  sh_codes[3] = value;
            default:       ;  // indexes past the transmit slot are not implemented
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // The model field is two bits wide, so the upper data bits carry junk on purpose.
    task automatic set_model(input t_model m);
        set_reg(REG_MODEL, {22'($urandom_range(22'h3fffff, 0)), m});
    endtask

    // Slot codes lean toward the all-zero and all-one extremes.
    function automatic logic [23:0] pick_code();
        case ($urandom_range(3))
            0:       return 24'h000000;
            1:       return 24'hffffff;
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic set_all_codes();
        set_reg(REG_HEARTBEAT, pick_code());
        set_reg(REG_DISK,      pick_code());
        set_reg(REG_RECEIVE,   pick_code());
        set_reg(REG_TRANSMIT,  pick_code());
    endtask

    function automatic void owe_write(input logic port, input logic [7:0] data,
                                      input logic last);
        t_write_rec w;
        w.port = port;
        w.data = data;
        w.last = last;
        pending_writes.push_back(w);
        predicted_writes++;
    endfunction

    // Advances the shadow state by one accepted request and queues the display
    // writes it should cause.
    function automatic void advance_display(input logic t);
        logic [23:0] codes;
        logic [7:0]  inv;
        int          b;
        // An idle request, or any request with no display fitted, leaves all state alone.
        if (!t || sh_model == MODEL_NONE)
            return;
        tick_ctr = (tick_ctr == TICKS - 1) ? '0 : tick_ctr + 1'b1;
        pattern[3] = (tick_ctr % (TICKS / 2)) < (TICKS / 16);
        // The roll moves on once per wrap of the tick counter.
        if (tick_ctr == 0) begin
            roll_idx     = (roll_idx == 2'd2) ? 2'd0 : roll_idx + 2'd1;
            pattern[2:0] = 3'b001 << roll_idx;
        end
        // Nothing goes out unless the pattern changed, except before the first showing.
        if (shown_ok && shown == pattern)
            return;
        case (sh_model)
            MODEL_LCD: begin
                // One write per change: the slot's command, then its on or off byte.
                codes = sh_codes[lcd_slot];
                if (data_next) begin
                    owe_write(PORT_DATA, pattern[3 - lcd_slot] ? codes[15:8] : codes[7:0],
                              1'b1);
                    data_next = 1'b0;
                    lcd_slot  = lcd_slot + 2'd1;
                end else begin
                    owe_write(PORT_CMD, codes[23:16], 1'b1);
                    data_next = 1'b1;
                end
            end
            MODEL_PARALLEL: begin
                owe_write(PORT_CMD, ~pattern, 1'b1);
            end
            default: begin
                // Serial LEDs take each inverted bit MSB first, plain and then strobed.
                inv = ~pattern;
                for (b = 7; b >= 0; b--) begin
                    owe_write(PORT_CMD, {7'b0, inv[b]}, 1'b0);
                    owe_write(PORT_CMD, {6'b0, 1'b1, inv[b]}, b == 0);
                end
            end
        endcase
        shown    = pattern;
        shown_ok = 1'b1;
    endfunction

    // Offers one request and waits for the block to take it. Called and returning
    // at a falling edge; valid is left high so back-to-back requests need no toggle.
    task automatic send_tick(input logic t);
        i_in_valid <= 1'b1;
        i_tick     <= t;
        do
            @(posedge i_clk);
        while (o_in_stall);
        advance_display(t);
        @(negedge i_clk);
    endtask

    task automatic pause(input int cycles);
        if (cycles > 0) begin
            i_in_valid <= 1'b0;
            repeat (cycles) @(negedge i_clk);
        end
    endtask

    // Stops offering requests and waits until every owed write has come out, plus a
    // few cycles for requests that cause nothing but may still be in the front end.
    task automatic drain();
        int waited;
        waited = 0;
        i_in_valid <= 1'b0;
        while (pending_writes.size() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge i_clk);
            waited++;
        end
        if (pending_writes.size() != 0) begin
            $display("%0t: %0d expected writes never arrived, next expected port %0d byte %02h",
                     $time, pending_writes.size(), pending_writes[0].port,
                     pending_writes[0].data);
            mismatches += pending_writes.size();
            pending_writes.delete();
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Sends bursts of requests until enough real ticks went in and enough writes
    // are owed. Idle requests do not count.
    task automatic run_ticks(input int want_ticks, input int want_writes,
                             input int idle_pct, input int gap_max);
        int   counted;
        int   writes_at_start;
        int   burst;
        logic t;
        counted         = 0;
        writes_at_start = predicted_writes;
        while (counted < want_ticks || predicted_writes - writes_at_start < want_writes) begin
            burst = $urandom_range(12, 1);
            repeat (burst) begin
                t = $urandom_range(99) >= idle_pct;
                if (t)
                    counted++;
                send_tick(t);
            end
            if (gap_max > 0)
                pause($urandom_range(gap_max));
        end
    endtask

    // With no display fitted nothing moves and nothing comes out.
    task automatic test_no_display();
        stall_pct = 0;
        send_tick(1'b1);
        send_tick(1'b0);
        drain();
    endtask

    // The first tick on an LCD always writes, and codes survive writes to unused indexes.
    task automatic test_lcd_directed();
        set_model(MODEL_LCD);
        set_reg(REG_HEARTBEAT, 24'hffffff);
        set_reg(REG_DISK,      24'h000000);
        set_reg(REG_RECEIVE,   24'ha5c33c);
        set_reg(REG_TRANSMIT,  24'h5a3cc3);
        set_reg(3'd5, 24'h123456);
        set_reg(3'd6, 24'hffffff);
        set_reg(3'd7, 24'hedcba9);
        send_tick(1'b1);
        send_tick(1'b0);
        repeat (8) send_tick(1'b1);
        drain();
    endtask

    // Parallel and serial models, switched without touching the state.
    task automatic test_led_directed();
        set_model(MODEL_PARALLEL);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b1);
        drain();
        set_model(MODEL_SERIAL);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b1);
        drain();
    endtask

    task automatic test_lcd_random();
        set_model(MODEL_LCD);
        set_all_codes();
        stall_pct = 30;
        run_ticks(20, 0, 15, 6);
        drain();
        set_reg(REG_HEARTBEAT, 24'h000000);
        set_reg(REG_TRANSMIT,  24'hffffff);
        stall_pct = 0;
        run_ticks(12, 0, 10, 0);
        drain();
    endtask

    task automatic test_parallel_random();
        set_model(MODEL_PARALLEL);
        stall_pct = 60;
        run_ticks(20, 0, 15, 6);
        drain();
    endtask

    task automatic test_serial_random();
        set_model(MODEL_SERIAL);
        stall_pct = 60;
        run_ticks(16, 0, 15, 4);
        drain();
        stall_pct = 0;
        run_ticks(8, 0, 0, 0);
        drain();
    endtask

    // Several phases with a random model and random codes each, none included.
    task automatic test_model_switching();
        repeat (5) begin
            set_model(t_model'($urandom_range(3)));
            set_all_codes();
            stall_pct = $urandom_range(2) * 30;
            run_ticks(6, 0, 15, 4);
            drain();
        end
    endtask

    // The receiver holds off for a long stretch while requests keep coming, so the
    // job queue fills and the block has to stall its input.
    task automatic test_backpressure();
        set_model(MODEL_SERIAL);
        stall_pct = 20;
        hold_requests++;
        run_ticks(110, 0, 0, 0);
        drain();
    endtask

    // The receiver keeps its stall level for a random run, then picks a new one.
    always @(negedge i_clk) begin
        if (hold_requests != hold_served) begin
            hold_served <= hold_requests;
            hold_left   <= HOLD_LEN;
            i_out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (run_left != 0) begin
            run_left <= run_left - 1;
        end else begin
            run_left    <= $urandom_range(7);
            i_out_stall <= $urandom_range(99) < stall_pct;
        end
    end

    // Every write the block hands over is matched against the oldest owed write.
    always @(posedge i_clk) begin : check_writes
        t_write_rec want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_writes.size() == 0) begin
                $display("%0t: unexpected write, expected none, got port %0d byte %02h last %0d",
                         $time, o_target_port, o_write_byte, o_last_write);
                mismatches++;
            end else begin
                want = pending_writes.pop_front();
                if (o_target_port !== want.port) begin
                    $display("%0t: target_port expected %0d, got %0d",
                             $time, want.port, o_target_port);
                    mismatches++;
                end
                if (o_write_byte !== want.data) begin
                    $display("%0t: write_byte expected %02h, got %02h",
                             $time, want.data, o_write_byte);
                    mismatches++;
                end
                if (o_last_write !== want.last) begin
                    $display("%0t: last_write expected %0d, got %0d",
                             $time, want.last, o_last_write);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run here.
    initial begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAIL tick_led_display_driver");
        $finish;
    end

    initial begin
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_no_display();
        test_lcd_directed();
        test_led_directed();
        test_lcd_random();
        test_parallel_random();
        test_serial_random();
        test_model_switching();
        test_backpressure();

        if (mismatches == 0) begin
            $display("PASS tick_led_display_driver");
        end else begin
            $display("FAIL tick_led_display_driver");
        end
        $finish;
    end

endmodule

>>> sim.f
hdl/tld_pkg.sv
hdl/tld_front.sv
hdl/tld_queue.sv
hdl/tld_back.sv
hdl/tick_led_display_driver.sv
tb/testbench.sv
